// ----- sv/bre_pkg.sv -----
// Shared types, widths and helpers for the Bresenham line rasterizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bre_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W = 10;
  localparam int COLOR_W = 32;
  localparam int WIDTH_W = 11;
  localparam int ADDR_W  = 20;
  localparam int ERR_W   = 12;

  // Largest drawable dimension; coordinates at or above it saturate.
  localparam int MAX_DIM = 1024;

  // Row stride after reset.
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1024);

  // Command queue between front and back; depth is a power of two.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Input action codes.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    logic               is_load;
    logic               steep;
    logic [COORD_W-1:0] major_start;
    logic [COORD_W-1:0] minor_start;
    logic [COORD_W-1:0] major_end;
    logic [COORD_W-1:0] major_delta;
    logic [COORD_W-1:0] minor_delta;
    logic               step_down;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  // Saturate a coordinate to the drawable range.
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] c;
    c = v;
    if (int'(c) >= MAX_DIM) begin
      c = COORD_W'(MAX_DIM - 1);
    end
    return c;
  endfunction

  // Absolute difference of two coordinates.
  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ----- sv/bre_front.sv -----
// Front end: takes input beats, classifies them and prepares line setup.
// Depends on bre_pkg; feeds bre_queue.
`default_nettype none

module bre_front import bre_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [COORD_W-1:0] in_start_x,
  input  logic [COORD_W-1:0] in_start_y,
  input  logic [COORD_W-1:0] in_end_x,
  input  logic [COORD_W-1:0] in_end_y,
  input  logic [COLOR_W-1:0] in_line_color,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  // A beat is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Line setup: saturate, pick the major axis, order by major coordinate.
  always_comb begin
    logic [COORD_W-1:0] sx, sy, ex, ey;
    logic [COORD_W-1:0] a0, b0, a1, b1;
    logic               steep;
    sx    = clamp_coord(in_start_x);
    sy    = clamp_coord(in_start_y);
    ex    = clamp_coord(in_end_x);
    ey    = clamp_coord(in_end_y);
    steep = abs_diff(ey, sy) > abs_diff(ex, sx);
    if (steep) begin
      a0 = sy; b0 = sx; a1 = ey; b1 = ex;
    end else begin
      a0 = sx; b0 = sy; a1 = ex; b1 = ey;
    end
    if (a0 > a1) begin
      q_cmd.major_start = a1;
      q_cmd.minor_start = b1;
      q_cmd.major_end   = a0;
      q_cmd.major_delta = a0 - a1;
      q_cmd.minor_delta = abs_diff(b1, b0);
      q_cmd.step_down   = b1 > b0;
    end else begin
      q_cmd.major_start = a0;
      q_cmd.minor_start = b0;
      q_cmd.major_end   = a1;
      q_cmd.major_delta = a1 - a0;
      q_cmd.minor_delta = abs_diff(b0, b1);
      q_cmd.step_down   = b0 > b1;
    end
    q_cmd.is_load = (action_t'(in_action) == ACT_LOAD);
    q_cmd.steep   = steep;
    q_cmd.color   = in_line_color;
  end

endmodule

`default_nettype wire

// ----- sv/bre_queue.sv -----
// Short command queue that decouples the front end from the stepper.
// Depends on bre_pkg for the command type and depth.
`default_nettype none

module bre_queue import bre_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic rd_valid,
  output logic full
);

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign rd_cmd   = entry_r[rd_ptr_r];
  assign rd_valid = (count_r != '0);
  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));

  // Pointers wrap naturally because the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; only counted entries are ever read.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bre_back.sv -----
// Back end: holds the active line, steps it one pixel per step command and forms
// the linear address in an output stage. Depends on bre_pkg.
`default_nettype none

module bre_back import bre_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  input  logic [WIDTH_W-1:0] image_width,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic [ADDR_W-1:0]  out_pixel_address,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic               out_last_pixel
);

  // Line state.
  logic                    active_r, active_nxt;
  logic                    steep_r, steep_nxt;
  logic [COORD_W-1:0]      major_pos_r, major_pos_nxt;
  logic [COORD_W-1:0]      minor_pos_r, minor_pos_nxt;
  logic [COORD_W-1:0]      major_end_r, major_end_nxt;
  logic [COORD_W-1:0]      major_delta_r, major_delta_nxt;
  logic [COORD_W-1:0]      minor_delta_r, minor_delta_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic                    down_r, down_nxt;
  logic [COLOR_W-1:0]      color_r, color_nxt;

  // Pixel stage and output stage.
  logic                    p1_valid_r, p1_valid_nxt;
  logic [COORD_W-1:0]      p1_x_r, p1_x_nxt;
  logic [COORD_W-1:0]      p1_y_r, p1_y_nxt;
  logic [COLOR_W-1:0]      p1_color_r, p1_color_nxt;
  logic                    p1_last_r, p1_last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]      out_x_r, out_x_nxt;
  logic [COORD_W-1:0]      out_y_r, out_y_nxt;
  logic [ADDR_W-1:0]       out_addr_r, out_addr_nxt;
  logic [COLOR_W-1:0]      out_color_r, out_color_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    p1_adv, p1_load, exec_step, last;
  logic signed [ERR_W-1:0] err_sub;
  logic [COORD_W+WIDTH_W-1:0] row_base, addr_full;

  // Stage advance: the output moves when free or taken, the pixel stage
  // loads when it is empty or moving on.
  assign p1_adv    = !out_valid_r || out_ready;
  assign p1_load   = !p1_valid_r || p1_adv;
  assign cmd_pop   = cmd_valid && p1_load;
  assign exec_step = cmd_pop && !cmd.is_load && active_r;
  assign last      = major_pos_r >= major_end_r;

  // One error update per step: subtract the minor delta, fold back on underflow.
  assign err_sub = err_r - $signed({{(ERR_W-COORD_W){1'b0}}, minor_delta_r});

  // Stepper next state.
  always_comb begin
    active_nxt      = active_r;
    steep_nxt       = steep_r;
    major_pos_nxt   = major_pos_r;
    minor_pos_nxt   = minor_pos_r;
    major_end_nxt   = major_end_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    err_nxt         = err_r;
    down_nxt        = down_r;
    color_nxt       = color_r;
    if (cmd_pop && cmd.is_load) begin
      active_nxt      = 1'b1;
      steep_nxt       = cmd.steep;
      major_pos_nxt   = cmd.major_start;
      minor_pos_nxt   = cmd.minor_start;
      major_end_nxt   = cmd.major_end;
      major_delta_nxt = cmd.major_delta;
      minor_delta_nxt = cmd.minor_delta;
      err_nxt         = $signed(ERR_W'(cmd.major_delta >> 1));
      down_nxt        = cmd.step_down;
      color_nxt       = cmd.color;
    end else if (exec_step) begin
      err_nxt = err_sub;
      if (err_sub < 0) begin
        minor_pos_nxt = down_r ? minor_pos_r - 1'b1 : minor_pos_r + 1'b1;
        err_nxt       = err_sub + $signed({{(ERR_W-COORD_W){1'b0}}, major_delta_r});
      end
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        major_pos_nxt = major_pos_r + 1'b1;
      end
    end
  end

  // Pixel stage: coordinates back in x/y order.
  always_comb begin
    p1_valid_nxt = p1_valid_r;
    p1_x_nxt     = p1_x_r;
    p1_y_nxt     = p1_y_r;
    p1_color_nxt = p1_color_r;
    p1_last_nxt  = p1_last_r;
    if (p1_load) begin
      p1_valid_nxt = exec_step;
      p1_x_nxt     = steep_r ? minor_pos_r : major_pos_r;
      p1_y_nxt     = steep_r ? major_pos_r : minor_pos_r;
      p1_color_nxt = color_r;
      p1_last_nxt  = last;
    end
  end

  // Output stage: linear address is row times stride plus column, modulo 2^20.
  assign row_base  = {{WIDTH_W{1'b0}}, p1_y_r} * {{COORD_W{1'b0}}, image_width};
  assign addr_full = row_base + (COORD_W+WIDTH_W)'(p1_x_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_addr_nxt  = out_addr_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    if (p1_adv) begin
      out_valid_nxt = p1_valid_r;
      out_x_nxt     = p1_x_r;
      out_y_nxt     = p1_y_r;
      out_addr_nxt  = addr_full[ADDR_W-1:0];
      out_color_nxt = p1_color_r;
      out_last_nxt  = p1_last_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    steep_r       <= steep_nxt;
    major_pos_r   <= major_pos_nxt;
    minor_pos_r   <= minor_pos_nxt;
    major_end_r   <= major_end_nxt;
    major_delta_r <= major_delta_nxt;
    minor_delta_r <= minor_delta_nxt;
    err_r         <= err_nxt;
    down_r        <= down_nxt;
    color_r       <= color_nxt;
    p1_x_r        <= p1_x_nxt;
    p1_y_r        <= p1_y_nxt;
    p1_color_r    <= p1_color_nxt;
    p1_last_r     <= p1_last_nxt;
    out_x_r       <= out_x_nxt;
    out_y_r       <= out_y_nxt;
    out_addr_r    <= out_addr_nxt;
    out_color_r   <= out_color_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = out_x_r;
  assign out_pixel_y       = out_y_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;
  assign out_last_pixel    = out_last_r;

endmodule

`default_nettype wire

// ----- sv/bresenham_line_rasterizer.sv -----
// Bresenham line rasterizer, top level.
// A taken step beat is registered in the queue, the pixel stage and then the
// output stage; loads produce no output beat. Throughput: one beat per cycle
// while the output is not stalled, set by the stepper's single add-compare error
// update per pixel. Reset is synchronous and active low: it empties the queue,
// drops the active line and output valid, and sets the stride to 1024.
`default_nettype none

module bresenham_line_rasterizer import bre_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [COORD_W-1:0] in_start_x,
  input  logic [COORD_W-1:0] in_start_y,
  input  logic [COORD_W-1:0] in_end_x,
  input  logic [COORD_W-1:0] in_end_y,
  input  logic [COLOR_W-1:0] in_line_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic [ADDR_W-1:0]  out_pixel_address,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic               out_last_pixel
);

  logic [WIDTH_W-1:0] image_width_r;
  logic               q_push, q_pop, q_valid, q_full;
  cmd_t               q_wr_cmd, q_rd_cmd;

  // Row stride register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= WIDTH_RESET;
    end else if (cfg_wr_en) begin
      image_width_r <= cfg_wr_data;
    end
  end

  // Front end: intake and line setup.
  bre_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_line_color (in_line_color),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_wr_cmd)
  );

  // Command queue.
  bre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_cmd   (q_wr_cmd),
    .pop      (q_pop),
    .rd_cmd   (q_rd_cmd),
    .rd_valid (q_valid),
    .full     (q_full)
  );

  // Back end: stepper and address stage.
  bre_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (q_valid),
    .cmd               (q_rd_cmd),
    .cmd_pop           (q_pop),
    .image_width       (image_width_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last_pixel    (out_last_pixel)
  );

  // A taken beat is waiting in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> q_valid)
    else $error("accepted beat missing from command queue");

  // The stepper only pulls commands that are present.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // Reset leaves the block empty and ready.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for bresenham_line_rasterizer: random and directed
// load/step beats, with every output pixel checked against a scoreboard prediction.
// Depends on bre_pkg and the bresenham_line_rasterizer RTL.
module testbench;
  import bre_pkg::*;

  // One expected or observed output pixel.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  // Tracks the line being walked and holds the pixels still owed by the block.
  class pixel_scoreboard;
    logic [WIDTH_W-1:0] stride;
    bit                 active;
    bit                 steep;
    bit                 step_down;
    logic [COORD_W-1:0] major_pos;
    logic [COORD_W-1:0] minor_pos;
    logic [COORD_W-1:0] major_end;
    logic [COORD_W-1:0] major_delta;
    logic [COORD_W-1:0] minor_delta;
    int                 err_term;
    logic [COLOR_W-1:0] color;
    pixel_t             pixels_due[$];
    int unsigned        mismatches;

    function new();
      mismatches = 0;
      stride = WIDTH_RESET;
      active = 0;
      steep = 0;
      step_down = 0;
      major_pos = '0;
      minor_pos = '0;
      major_end = '0;
      major_delta = '0;
      minor_delta = '0;
      err_term = 0;
      color = '0;
    endfunction

    function void set_stride(logic [WIDTH_W-1:0] w);
      stride = w;
    endfunction

    function int unsigned pending();
      return pixels_due.size();
    endfunction

    function logic [COORD_W-1:0] span(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Notes an accepted input beat; returns 1 when it will produce a pixel.
    function bit take_command(action_t act, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                              logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                              logic [COLOR_W-1:0] c);
      logic [COORD_W-1:0] a0, b0, a1, b1, t;
      logic [31:0]        linear;
      pixel_t             p;
      if (act == ACT_LOAD) begin
        // Walk the longer axis, with the major coordinate increasing.
        steep = span(ey, sy) > span(ex, sx);
        if (steep) begin
          a0 = sy; b0 = sx; a1 = ey; b1 = ex;
        end else begin
          a0 = sx; b0 = sy; a1 = ex; b1 = ey;
        end
        if (a0 > a1) begin
          t = a0; a0 = a1; a1 = t;
          t = b0; b0 = b1; b1 = t;
        end
        major_pos = a0;
        minor_pos = b0;
        major_end = a1;
        major_delta = a1 - a0;
        minor_delta = span(b0, b1);
        err_term = int'(major_delta) / 2;
        step_down = b0 > b1;
        color = c;
        active = 1;
        return 0;
      end
      if (!active) begin
        return 0;
      end
      // Emit the current pixel, then advance one step along the major axis.
      p.x = steep ? minor_pos : major_pos;
      p.y = steep ? major_pos : minor_pos;
      p.last = (major_pos >= major_end);
      linear = 32'(p.y) * 32'(stride) + 32'(p.x);
      p.address = linear[ADDR_W-1:0];
      p.color = color;
      pixels_due.push_back(p);
      err_term -= int'(minor_delta);
      if (err_term < 0) begin
        minor_pos = step_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
        err_term += int'(major_delta);
      end
      if (p.last) begin
        active = 0;
      end else begin
        major_pos = major_pos + 1'b1;
      end
      return 1;
    endfunction

    // Compares an accepted output beat with the oldest pixel still owed.
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel beat: x=%0d y=%0d", got.x, got.y);
        mismatches++;
        return;
      end
      want = pixels_due.pop_front();
      if (got.x !== want.x) begin
        $error("pixel_x: expected %0d, got %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("pixel_y: expected %0d, got %0d", want.y, got.y);
        mismatches++;
      end
      if (got.address !== want.address) begin
        $error("pixel_address: expected %0d, got %0d", want.address, got.address);
        mismatches++;
      end
      if (got.color !== want.color) begin
        $error("pixel_color: expected %h, got %h", want.color, got.color);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_pixel: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [WIDTH_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic               in_action;
  logic [COORD_W-1:0] in_start_x;
  logic [COORD_W-1:0] in_start_y;
  logic [COORD_W-1:0] in_end_x;
  logic [COORD_W-1:0] in_end_y;
  logic [COLOR_W-1:0] in_line_color;
  logic               out_valid;
  logic               out_ready;
  logic [COORD_W-1:0] out_pixel_x;
  logic [COORD_W-1:0] out_pixel_y;
  logic [ADDR_W-1:0]  out_pixel_address;
  logic [COLOR_W-1:0] out_pixel_color;
  logic               out_last_pixel;

  pixel_scoreboard board;
  int unsigned     beats_counted;
  bit              tx_burst;
  bit              rx_burst;
  bit              hold_request;

  bresenham_line_rasterizer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_line_color    (in_line_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_address(out_pixel_address),
    .out_pixel_color  (out_pixel_color),
    .out_last_pixel   (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Offers one input beat, after a random gap unless in a burst, and waits until it is taken.
  task automatic send_beat(action_t act, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                           logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                           logic [COLOR_W-1:0] c);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_end_x      <= ex;
    in_end_y      <= ey;
    in_line_color <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (board.take_command(act, sx, sy, ex, ey, c) || act == ACT_LOAD) begin
      beats_counted++;
    end
  endtask

  // Step beats carry random values in the unused fields.
  task automatic send_step();
    send_beat(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), $urandom);
  endtask

  task automatic run_line(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                          logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                          logic [COLOR_W-1:0] c, int unsigned steps);
    send_beat(ACT_LOAD, sx, sy, ex, ey, c);
    repeat (steps) send_step();
  endtask

  // Stops offering beats until every pixel is out and the queue has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_stride(logic [WIDTH_W-1:0] w);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_stride(w);
  endtask

  // A coordinate within a window around a base point, kept on screen.
  function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] base, int reach);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) begin
      v = 0;
    end
    if (v > MAX_DIM - 1) begin
      v = MAX_DIM - 1;
    end
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] pick_start();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 1) ? COORD_W'(MAX_DIM - 1) : '0;
    end
    return COORD_W'($urandom);
  endfunction

  // Mostly complete short lines with random content, some cut short, some noise.
  task automatic random_phase(int unsigned budget);
    int unsigned        stop_at;
    int unsigned        kind;
    int unsigned        len;
    int unsigned        steps;
    int                 reach;
    logic [COORD_W-1:0] sx, sy, ex, ey;
    stop_at = beats_counted + budget;
    while (beats_counted < stop_at) begin
      kind = $urandom_range(0, 99);
      tx_burst = ($urandom_range(0, 3) == 0);
      if (kind < 8) begin
        send_beat($urandom_range(0, 1) ? ACT_STEP : ACT_LOAD, COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), $urandom);
      end else begin
        reach = ($urandom_range(0, 9) == 0) ? 63 : 15;
        sx = pick_start();
        sy = pick_start();
        ex = nudge(sx, reach);
        ey = nudge(sy, reach);
        len = int'(board.span(ex, sx));
        if (int'(board.span(ey, sy)) > len) begin
          len = int'(board.span(ey, sy));
        end
        len++;
        if (kind < 18) begin
          steps = $urandom_range(0, len - 1);
        end else if ($urandom_range(0, 4) == 0) begin
          steps = len + $urandom_range(1, 2);
        end else begin
          steps = len;
        end
        run_line(sx, sy, ex, ey, $urandom, steps);
      end
    end
  endtask

  // Output side: random stalls per beat, burst stretches and one long hold-off.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    rx_burst = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if ($urandom_range(0, 31) == 0) begin
        rx_burst = ~rx_burst;
      end
    end
  end

  // Check every pixel beat the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_pixel(pixel_t'{out_pixel_x, out_pixel_y, out_pixel_address,
                                 out_pixel_color, out_last_pixel});
    end
  end

  // Main sequence: reset, directed lines, then random phases at several strides.
  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_action = ACT_LOAD;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    in_line_color = '0;
    beats_counted = 0;
    tx_burst = 1'b0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // A step before any load produces nothing.
    send_step();
    // Single-point line at the right edge, then a step past its end.
    run_line(10'd1023, 10'd0, 10'd1023, 10'd0, 32'hFFFF_FFFF, 2);
    // Shallow line from the left edge whose minor axis steps down.
    run_line(10'd0, 10'd1023, 10'd2, 10'd1022, 32'h0000_0000, 3);
    // Steep line given top end first, replaced by a new load halfway.
    run_line(10'd1023, 10'd1023, 10'd1022, 10'd1020, 32'hA5A5_5A5A, 2);
    // Exact diagonal.
    run_line(10'd1, 10'd1, 10'd3, 10'd3, 32'h1234_5678, 3);
    // Shallow line given right end first.
    run_line(10'd3, 10'd0, 10'd0, 10'd1, 32'h8000_0001, 4);

    write_stride(11'd1);
    random_phase(120);

    // Full-height steep line at the widest stride; addresses wrap.
    write_stride(11'd2047);
    hold_request = 1'b1;
    tx_burst = 1'b1;
    run_line(COORD_W'($urandom_range(0, 1022)), 10'd0, COORD_W'($urandom_range(0, 1022)),
             10'd1023, $urandom, 1024);
    random_phase(80);

    write_stride(11'd0);
    random_phase(120);

    write_stride(11'd1024);
    random_phase(120);

    write_stride(WIDTH_W'($urandom_range(2, 1023)));
    random_phase(120);

    settle();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
